>>> hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared sizes, types and operation / status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int MAP_WORDS     = 1024;
	localparam int BITS_PER_WORD = 32;
	localparam int BIT_W         = $clog2(BITS_PER_WORD);
	localparam int WORD_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HINT_W        = WORD_W + BIT_W;
	localparam int FULL_W        = WORD_W + 1;
	localparam int TOTAL_BLOCKS  = MAP_WORDS * BITS_PER_WORD;
	localparam int PAGE_W        = 32;
	localparam int COUNT_W       = 16;

	typedef logic [BITS_PER_WORD-1:0] word_t;
	typedef logic [WORD_W-1:0]        word_idx_t;
	typedef logic [HINT_W-1:0]        hint_t;
	typedef logic [PAGE_W-1:0]        page_t;
	typedef logic [COUNT_W-1:0]       count_t;

	localparam word_idx_t WORD_LAST = word_idx_t'(MAP_WORDS - 1);

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RESERVE = 2'd2,
		OP_FREE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_RESERVED = 2'd2
	} status_t;

endpackage

>>> hdl/bpa_req_if.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator request channel
// Valid/ready channel carrying one operation transaction.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	import bpa_pkg::*;

	logic   valid;
	logic   ready;
	op_t    operation;
	page_t  page_number;
	count_t block_count;

	modport source (output valid, output operation, output page_number, output block_count,
		input ready);
	modport sink (input valid, input operation, input page_number, input block_count,
		output ready);
endinterface

>>> hdl/bpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
	import bpa_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	page_t   result_page;
	count_t  free_count;

	modport source (output valid, output status, output result_page, output free_count,
		input ready);
	modport sink (input valid, input status, input result_page, input free_count,
		output ready);
endinterface

>>> hdl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> hdl/bpa_find.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator free-bit finder
// Priority encoder for the lowest clear bit of a bitmap word.
// ----------------------------------------------------------------------------
module bpa_find (
	input  bpa_pkg::word_t               word,
	output logic                         found,
	output logic [bpa_pkg::BIT_W-1:0]    index
);
	import bpa_pkg::*;

	always_comb begin
		found = |(~word);
		index = '0;
		for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
			if (!word[i]) begin
				index = BIT_W'(i);
			end
		end
	end
endmodule

>>> hdl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Free-space bitmap with base page, free counter and next-free hint.
// ----------------------------------------------------------------------------
// The bitmap lives in one RAM of MAP_WORDS 32-bit words (one read and one
// write per cycle). After reset the block sets every word to all ones and
// takes no request meanwhile. Init rewrites the whole map. Free reads the
// page's word (LOOKUP) and rewrites it (MODIFY); a free or a reserve of a
// page out of range goes straight to DONE. Allocate and reserve look the bit
// up the same way and go to DONE when refused; when they succeed, SCAN
// walks the map a word a cycle from the hint's word until it finds a clear
// bit or reaches the last word. One transaction is in flight at a time; a
// finished result waits in the output register until taken.
module bitmap_page_allocator (
	input  logic      clk,
	input  logic      arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);
	import bpa_pkg::*;

	typedef enum logic [2:0] {FILL, IDLE, LOOKUP, MODIFY, SCAN, DONE} state_t;

	state_t              state_q;
	op_t                 op_q;
	word_idx_t           addr_q;
	logic [BIT_W-1:0]    bit_q;
	logic [FULL_W-1:0]   full_q;
	logic [BIT_W-1:0]    rem_q;
	logic                fill_rsp_q;
	page_t               base_q;
	count_t              cnt_q;
	hint_t               hint_q;
	logic                issue_q;
	logic                rdv_s1;
	word_idx_t           rword_s1;
	status_t             res_status_q;
	page_t               res_page_q;
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	page_t               rsp_page_q;
	count_t              rsp_count_q;

	page_t               pos;
	logic                in_range;
	page_t               n_clamp;
	word_t               fill_word;
	word_t               bit_mask;
	logic                bit_set;
	logic                find_found;
	logic [BIT_W-1:0]    find_idx;
	page_t               grant;
	word_idx_t           hint_word;

	logic                wr_en;
	word_idx_t           wr_addr;
	word_t               wr_data;
	logic                rd_en;
	word_idx_t           rd_addr;
	word_t               rd_data;

	assign pos       = req.page_number - base_q - page_t'(1);
	assign in_range  = pos < page_t'(TOTAL_BLOCKS);
	assign n_clamp   = (page_t'(req.block_count) > page_t'(TOTAL_BLOCKS)) ?
		page_t'(TOTAL_BLOCKS) : page_t'(req.block_count);
	assign bit_mask  = word_t'(1) << bit_q;
	assign bit_set   = |(rd_data & bit_mask);
	assign grant     = base_q + page_t'(hint_q) + page_t'(1);
	assign hint_word = hint_q[HINT_W-1:BIT_W];

	always_comb begin
		if ({1'b0, addr_q} < full_q) begin
			fill_word = '0;
		end else if (({1'b0, addr_q} == full_q) && (rem_q != '0)) begin
			fill_word = '1 << rem_q;
		end else begin
			fill_word = '1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = fill_word;
		rd_en   = 1'b0;
		rd_addr = addr_q;
		case (state_q)
			FILL: begin
				wr_en = 1'b1;
			end
			LOOKUP: begin
				rd_en = 1'b1;
			end
			MODIFY: begin
				case (op_q)
					OP_ALLOC: begin
						wr_en   = (cnt_q != '0) && !bit_set;
						wr_data = rd_data | bit_mask;
					end
					OP_RESERVE: begin
						wr_en   = !bit_set;
						wr_data = rd_data | bit_mask;
					end
					OP_FREE: begin
						wr_en   = bit_set;
						wr_data = rd_data & ~bit_mask;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			SCAN: begin
				rd_en = issue_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	bpa_ram #(
		.WIDTH(BITS_PER_WORD),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	bpa_find u_find (
		.word (rd_data),
		.found(find_found),
		.index(find_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FILL;
			op_q         <= OP_INIT;
			addr_q       <= '0;
			bit_q        <= '0;
			full_q       <= '0;
			rem_q        <= '0;
			fill_rsp_q   <= 1'b0;
			base_q       <= '0;
			cnt_q        <= '0;
			hint_q       <= '0;
			issue_q      <= 1'b0;
			rdv_s1       <= 1'b0;
			rword_s1     <= '0;
			res_status_q <= ST_OK;
			res_page_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_page_q   <= '0;
			rsp_count_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				FILL: begin
					addr_q <= addr_q + word_idx_t'(1);
					if (addr_q == WORD_LAST) begin
						addr_q       <= '0;
						res_status_q <= ST_OK;
						res_page_q   <= '0;
						state_q      <= fill_rsp_q ? DONE : IDLE;
					end
				end
				IDLE: begin
					if (req.valid) begin
						op_q         <= req.operation;
						res_status_q <= ST_OK;
						res_page_q   <= '0;
						case (req.operation)
							OP_INIT: begin
								base_q     <= req.page_number;
								cnt_q      <= COUNT_W'(n_clamp);
								hint_q     <= '0;
								full_q     <= FULL_W'(n_clamp >> BIT_W);
								rem_q      <= n_clamp[BIT_W-1:0];
								addr_q     <= '0;
								fill_rsp_q <= 1'b1;
								state_q    <= FILL;
							end
							OP_ALLOC: begin
								addr_q  <= hint_word;
								bit_q   <= hint_q[BIT_W-1:0];
								state_q <= LOOKUP;
							end
							OP_RESERVE: begin
								if (in_range) begin
									addr_q  <= WORD_W'(pos >> BIT_W);
									bit_q   <= pos[BIT_W-1:0];
									state_q <= LOOKUP;
								end else begin
									res_status_q <= ST_RESERVED;
									state_q      <= DONE;
								end
							end
							OP_FREE: begin
								if (in_range) begin
									addr_q  <= WORD_W'(pos >> BIT_W);
									bit_q   <= pos[BIT_W-1:0];
									if (HINT_W'(pos) < hint_q) begin
										hint_q <= HINT_W'(pos);
									end
									state_q <= LOOKUP;
								end else begin
									state_q <= DONE;
								end
							end
							default: begin
								state_q <= DONE;
							end
						endcase
					end
				end
				LOOKUP: begin
					state_q <= MODIFY;
				end
				MODIFY: begin
					case (op_q)
						OP_ALLOC: begin
							if ((cnt_q == '0) || bit_set) begin
								res_status_q <= ST_NO_FREE;
								state_q      <= DONE;
							end else begin
								cnt_q      <= cnt_q - count_t'(1);
								res_page_q <= grant;
								addr_q     <= hint_word;
								issue_q    <= 1'b1;
								rdv_s1     <= 1'b0;
								state_q    <= SCAN;
							end
						end
						OP_RESERVE: begin
							if (bit_set) begin
								res_status_q <= ST_RESERVED;
								state_q      <= DONE;
							end else begin
								if (cnt_q != '0) begin
									cnt_q <= cnt_q - count_t'(1);
								end
								addr_q  <= hint_word;
								issue_q <= 1'b1;
								rdv_s1  <= 1'b0;
								state_q <= SCAN;
							end
						end
						OP_FREE: begin
							if (bit_set && (cnt_q != '1)) begin
								cnt_q <= cnt_q + count_t'(1);
							end
							state_q <= DONE;
						end
						default: begin
							state_q <= DONE;
						end
					endcase
				end
				SCAN: begin
					rdv_s1   <= issue_q;
					rword_s1 <= addr_q;
					if (issue_q) begin
						addr_q <= addr_q + word_idx_t'(1);
						if (addr_q == WORD_LAST) begin
							issue_q <= 1'b0;
						end
					end
					if (rdv_s1) begin
						if (find_found) begin
							hint_q  <= {rword_s1, find_idx};
							issue_q <= 1'b0;
							state_q <= DONE;
						end else if (rword_s1 == WORD_LAST) begin
							hint_q  <= '0;
							issue_q <= 1'b0;
							state_q <= DONE;
						end
					end
				end
				DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_page_q   <= res_page_q;
						rsp_count_q  <= cnt_q;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.result_page = rsp_page_q;
	assign rsp.free_count  = rsp_count_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != IDLE))
		else $error("request accepted but controller stayed idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == DONE))
		else $error("result raised outside completion state");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE) |-> !wr_en)
		else $error("bitmap written while idle");

endmodule

>>> dv/tb_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives init, allocate, reserve and free transactions with random gaps and
// receiver stalls, including long hold-offs that back the block up. Every
// result is checked against a bit-accurate model of the bitmap, base page,
// free counter and next-free hint, kept inside this testbench.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
	import bpa_pkg::*;

	localparam int HOLD_CYCLES = 2500;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEMS = 580;

	typedef struct {
		op_t    op;
		page_t  page;
		count_t count;
	} req_t;

	typedef struct {
		status_t status;
		page_t   page;
		count_t  count;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();

	bitmap_page_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// allocator state as seen by the checker
	word_t       map_m [MAP_WORDS];
	page_t       base_m;
	int unsigned free_m;
	int unsigned hint_m;

	req_t pending_q[$];
	rsp_t outcome_q[$];
	req_t drv_item;
	int   gap_left;
	int   stall_left;
	bit   drv_quiet;
	bit   mon_quiet;
	bit   hold_rsp = 1'b0;
	int   sent_cnt;
	int   checked;
	int   mismatches;
	int   total_items;

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic int idle_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int unsigned lowest_free_from_hint();
		for (int w = hint_m / BITS_PER_WORD; w < MAP_WORDS; w++) begin
			if (~map_m[w] != '0) begin
				for (int b = 0; b < BITS_PER_WORD; b++) begin
					if (!map_m[w][b])
						return w * BITS_PER_WORD + b;
				end
			end
		end
		return 0;
	endfunction

	function automatic rsp_t allocator_outcome(req_t r);
		rsp_t        o;
		int unsigned pos;
		int unsigned w;
		int unsigned b;
		int unsigned n;
		int unsigned h;
		bit          in_range;
		page_t       diff;
		o.status = ST_OK;
		o.page = '0;
		diff = r.page - (base_m + page_t'(1));
		pos = diff;
		in_range = pos < TOTAL_BLOCKS;
		w = (pos / BITS_PER_WORD) % MAP_WORDS;
		b = pos % BITS_PER_WORD;
		case (r.op)
			OP_INIT: begin
				n = (r.count > TOTAL_BLOCKS) ? TOTAL_BLOCKS : r.count;
				for (int i = 0; i < MAP_WORDS; i++) begin
					if (i < n / BITS_PER_WORD)
						map_m[i] = '0;
					else if (i == n / BITS_PER_WORD && n % BITS_PER_WORD != 0)
						map_m[i] = ~word_t'(0) << (n % BITS_PER_WORD);
					else
						map_m[i] = '1;
				end
				base_m = r.page;
				free_m = (n > 65535) ? 65535 : n;
				hint_m = 0;
			end
			OP_ALLOC: begin
				h = hint_m % TOTAL_BLOCKS;
				if (free_m == 0 || map_m[h / BITS_PER_WORD][h % BITS_PER_WORD]) begin
					o.status = ST_NO_FREE;
				end else begin
					map_m[h / BITS_PER_WORD][h % BITS_PER_WORD] = 1'b1;
					hint_m = lowest_free_from_hint();
					free_m--;
					o.page = base_m + page_t'(1) + page_t'(h);
				end
			end
			OP_RESERVE: begin
				if (!in_range || map_m[w][b]) begin
					o.status = ST_RESERVED;
				end else begin
					map_m[w][b] = 1'b1;
					if (free_m > 0)
						free_m--;
					hint_m = lowest_free_from_hint();
				end
			end
			OP_FREE: begin
				if (in_range) begin
					if (hint_m > pos)
						hint_m = pos;
					if (map_m[w][b]) begin
						map_m[w][b] = 1'b0;
						if (free_m < 65535)
							free_m++;
					end
				end
			end
		endcase
		o.count = count_t'(free_m);
		return o;
	endfunction

	task automatic queue_item(op_t op, page_t page, count_t count);
		req_t r;
		r.op = op;
		r.page = page;
		r.count = count;
		pending_q.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= OP_INIT;
			req_ch.page_number <= '0;
			req_ch.block_count <= '0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				outcome_q.push_back(allocator_outcome(drv_item));
				sent_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if ($urandom_range(0, 149) == 0)
					drv_quiet = !drv_quiet;
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					drv_item = pending_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= drv_item.op;
					req_ch.page_number <= drv_item.page;
					req_ch.block_count <= drv_item.count;
					gap_left = idle_len(drv_quiet);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked++;
				if (outcome_q.size() == 0) begin
					report_mismatch("result transaction with nothing outstanding");
				end else begin
					want = outcome_q.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.result_page !== want.page)
						report_mismatch($sformatf("result_page %h, want %h",
							rsp_ch.result_page, want.page));
					if (rsp_ch.free_count !== want.count)
						report_mismatch($sformatf("free_count %0d, want %0d",
							rsp_ch.free_count, want.count));
				end
			end
			if ($urandom_range(0, 149) == 0)
				mon_quiet = !mon_quiet;
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = idle_len(mon_quiet);
			end
		end
	end

	// long receiver hold-offs so the block backs up and stalls requests
	initial begin
		for (int k = 0; k < 2; k++) begin
			while (checked < 40 + 310 * k)
				@(posedge clk);
			hold_rsp <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_rsp <= 1'b0;
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		page_t       base;
		int unsigned n;
		int unsigned pos;
		int unsigned span;
		int          len;
		int          r;
		op_t         op;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_INIT;
		req_ch.page_number = '0;
		req_ch.block_count = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < MAP_WORDS; i++)
			map_m[i] = '1;
		base_m = '0;
		free_m = 0;
		hint_m = 0;

		// straight after reset, every block is used
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_RESERVE, 32'd1, 16'd0);
		queue_item(OP_FREE, 32'd0, 16'd0);
		// freed block away from the hint: counter non-zero but hint bit used
		queue_item(OP_FREE, 32'd6, 16'd0);
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_RESERVE, 32'd6, 16'd0);
		// clamped init with page numbers wrapping through zero
		queue_item(OP_INIT, 32'hFFFF_FFF0, 16'hFFFF);
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_RESERVE, 32'hFFFF_FFF1, 16'd0);
		queue_item(OP_RESERVE, 32'h0000_0005, 16'd0);
		queue_item(OP_RESERVE, 32'hFFFF_FFF0, 16'd0);
		queue_item(OP_FREE, 32'hFFFF_FFF1, 16'd0);
		queue_item(OP_FREE, 32'hFFFF_FFF1, 16'd0);
		queue_item(OP_FREE, 32'h0000_7FF1, 16'd0);
		queue_item(OP_FREE, 32'hFFFF_FFFF, 16'd0);
		queue_item(OP_INIT, 32'd100, 16'd32);
		queue_item(OP_INIT, 32'd0, 16'd0);
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_INIT, 32'h8000_0000, 16'd37);
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_ALLOC, 32'd0, 16'd0);
		queue_item(OP_RESERVE, 32'h8000_0025, 16'd0);
		queue_item(OP_INIT, 32'h7FFF_FFFF, 16'h8000);
		queue_item(OP_FREE, 32'h7FFF_FFFF + 32'd32768, 16'd0);
		queue_item(OP_RESERVE, 32'h7FFF_FFFF + 32'd32768, 16'd0);

		// random sessions: an init followed by a run of operations on that map
		while (pending_q.size() < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				base = $urandom;
			else if (r < 85)
				base = 32'hFFFF_FFFF - $urandom_range(0, 64);
			else
				base = $urandom_range(0, 1000);
			r = $urandom_range(0, 99);
			if (r < 10)
				n = 0;
			else if (r < 50)
				n = $urandom_range(1, 40);
			else if (r < 65)
				n = 32 * $urandom_range(1, 6);
			else if (r < 80)
				n = $urandom_range(41, 200);
			else if (r < 90)
				n = $urandom_range(201, 2000);
			else if (r < 95)
				n = $urandom_range(32704, 32768);
			else
				n = $urandom_range(32769, 65535);
			queue_item(OP_INIT, base, count_t'(n));
			if (n > TOTAL_BLOCKS)
				n = TOTAL_BLOCKS;
			len = $urandom_range(8, 40);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					queue_item(OP_ALLOC, $urandom, count_t'($urandom));
				end else if (r < 94) begin
					op = (r < 65) ? OP_RESERVE : OP_FREE;
					if ($urandom_range(0, 9) == 0)
						pos = TOTAL_BLOCKS + $urandom_range(0, 40);
					else if (n < 64)
						pos = $urandom_range(0, n + 8);
					else if ($urandom_range(0, 3) == 0)
						pos = $urandom_range(0, TOTAL_BLOCKS - 1);
					else
						pos = $urandom_range(0, 96);
					queue_item(op, base + page_t'(1) + page_t'(pos), count_t'($urandom));
				end else begin
					op = ($urandom_range(0, 1) == 0) ? OP_RESERVE : OP_FREE;
					queue_item(op, $urandom, count_t'($urandom));
				end
			end
		end
		total_items = pending_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_cnt < total_items)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
